### rtl/core/efla_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efla_pkg
// Shared types and constants for the free-list block allocator core.
// ----------------------------------------------------------------------------
package efla_pkg;

  localparam int MaxBlocks = 255;
  localparam int IdxW      = 8;
  localparam int AddrW     = 32;
  localparam int SizeW     = 13;
  localparam int ProdW     = SizeW + IdxW;
  localparam int DivCntW   = $clog2(AddrW);

  typedef enum logic [1:0] {
    FUNC_FORMAT  = 2'd0,
    FUNC_ACQUIRE = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_QUERY   = 2'd3
  } func_t;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_EMPTY     = 2'd1;
  localparam logic [1:0] STAT_NOT_OWNED = 2'd2;
  localparam logic [1:0] STAT_MISALIGN  = 2'd3;

  localparam logic [1:0] OWN_BELOW  = 2'd0;
  localparam logic [1:0] OWN_INSIDE = 2'd1;
  localparam logic [1:0] OWN_ABOVE  = 2'd2;

  localparam logic [1:0] REG_BLOCK_SIZE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_COUNT  = 2'd1;
  localparam logic [1:0] REG_BASE_ADDRESS = 2'd2;

  typedef struct packed {
    logic            clear;
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    logic [IdxW-1:0] wr_data;
  } link_req_t;

  typedef struct packed {
    logic             done;
    logic [AddrW-1:0] quotient;
    logic [SizeW-1:0] remainder;
  } div_result_t;

endpackage

### rtl/core/efla_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efla_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module efla_divider
  import efla_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AddrW-1:0] dividend,
  input  logic [SizeW-1:0] divisor,
  output div_result_t      result
);

  logic [AddrW-1:0]   dq;
  logic [SizeW-1:0]   rem;
  logic [SizeW-1:0]   div_q;
  logic [DivCntW-1:0] cnt;
  logic               busy;
  logic               done;
  logic [SizeW:0]     shifted;
  logic               fits;

  assign shifted = {rem, dq[AddrW-1]};
  assign fits    = shifted >= {1'b0, div_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dq    <= dividend;
        rem   <= '0;
        div_q <= divisor;
        cnt   <= '0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= SizeW'(shifted - {1'b0, div_q});
        end else begin
          rem <= shifted[SizeW-1:0];
        end
        dq  <= {dq[AddrW-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == DivCntW'(AddrW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result.done      = done;
  assign result.quotient  = dq;
  assign result.remainder = rem;

endmodule

### rtl/core/efla_link_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efla_link_table
// Free-list link memory with per-entry valid bits; an invalid entry i reads i+1.
// ----------------------------------------------------------------------------
module efla_link_table
  import efla_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  link_req_t       req,
  output logic [IdxW-1:0] rd_data
);

  logic [IdxW-1:0]      mem [0:MaxBlocks-1];
  logic [MaxBlocks-1:0] valid;
  logic [IdxW-1:0]      rd_mem_q;
  logic                 rd_valid_q;
  logic [IdxW-1:0]      rd_addr_q;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_mem_q <= mem[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      if (req.clear) begin
        valid <= '0;
      end else if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_q <= valid[req.rd_addr];
        rd_addr_q  <= req.rd_addr;
      end
    end
  end

  assign rd_data = rd_valid_q ? rd_mem_q : rd_addr_q + 1'b1;

endmodule

### rtl/core/embedded_free_list_block_allocator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// embedded_free_list_block_allocator_core
// Free-list allocator for one chunk of up to 255 equal-sized blocks.
// ----------------------------------------------------------------------------
// One operation is in flight at a time. After acceptance, format and
// ownership query step through S_MUL and S_EVAL to S_OUT; a successful
// acquire adds S_LINK before S_OUT (one link-table read); release adds
// S_DIV, which waits for the 32-step radix-2 divider that turns the offset
// into a block index. An out-of-chunk release skips the divider. A finished
// result waits in the output register while the next transaction is
// accepted; that one then holds in the core until the output register frees.
// Configuration writes are always accepted but belong only where no
// transaction is in flight; block_count only takes effect at the next format.
module embedded_free_list_block_allocator_core
  import efla_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [AddrW-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       func,
  input  logic [AddrW-1:0] address,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [AddrW-1:0] block_address,
  output logic [IdxW-1:0]  block_index,
  output logic [1:0]       ownership,
  output logic [IdxW-1:0]  free_count,
  output logic [1:0]       status
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_EVAL, S_LINK, S_DIV, S_OUT
  } state_t;

  state_t           state;
  logic [SizeW-1:0] block_size;
  logic [IdxW-1:0]  block_count;
  logic [AddrW-1:0] base_address;
  logic [IdxW-1:0]  free_head;
  logic [IdxW-1:0]  free_total;
  logic [IdxW-1:0]  provided_total;
  func_t            func_q;
  logic [AddrW-1:0] addr_q;
  logic [ProdW-1:0] prod;
  logic [AddrW-1:0] res_addr;
  logic [IdxW-1:0]  res_index;
  logic [1:0]       res_own;
  logic [1:0]       res_status;

  logic [SizeW-1:0] eff_size;
  logic [AddrW:0]   sum;
  logic [1:0]       own;
  logic             div_start;
  logic             rel_ok;
  logic             out_load;
  link_req_t        link_req;
  logic [IdxW-1:0]  link_data;
  div_result_t      div_res;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_load  = (state == S_OUT) && (!out_valid || out_ready);
  assign eff_size  = (block_size == '0) ? SizeW'(1) : block_size;
  assign sum       = {1'b0, base_address} + (AddrW+1)'(prod);

  always_comb begin
    if (addr_q < base_address) begin
      own = OWN_BELOW;
    end else if ({1'b0, addr_q} >= sum) begin
      own = OWN_ABOVE;
    end else begin
      own = OWN_INSIDE;
    end
  end

  assign div_start = (state == S_EVAL) && (func_q == FUNC_RELEASE) && (own == OWN_INSIDE);
  assign rel_ok    = (div_res.remainder == '0) &&
                     (div_res.quotient < AddrW'(MaxBlocks));

  always_comb begin
    link_req         = '0;
    link_req.clear   = (state == S_EVAL) && (func_q == FUNC_FORMAT);
    link_req.rd_en   = (state == S_EVAL) && (func_q == FUNC_ACQUIRE);
    link_req.rd_addr = free_head;
    link_req.wr_en   = (state == S_DIV) && div_res.done && rel_ok;
    link_req.wr_addr = div_res.quotient[IdxW-1:0];
    link_req.wr_data = free_head;
  end

  efla_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (addr_q - base_address),
    .divisor  (eff_size),
    .result   (div_res)
  );

  efla_link_table u_links (
    .clk     (clk),
    .rst     (rst),
    .req     (link_req),
    .rd_data (link_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= SizeW'(16);
      block_count  <= IdxW'(255);
      base_address <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BLOCK_SIZE:   block_size   <= cfg_data[SizeW-1:0];
        REG_BLOCK_COUNT:  block_count  <= cfg_data[IdxW-1:0];
        REG_BASE_ADDRESS: base_address <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      out_valid      <= 1'b0;
      free_head      <= '0;
      free_total     <= IdxW'(MaxBlocks);
      provided_total <= IdxW'(MaxBlocks);
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_q <= func_t'(func);
            addr_q <= address;
            state  <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= ProdW'(eff_size) *
                   ProdW'((func_q == FUNC_ACQUIRE) ? free_head : provided_total);
          state <= S_EVAL;
        end
        S_EVAL: begin
          res_addr   <= '0;
          res_index  <= '0;
          res_own    <= OWN_BELOW;
          res_status <= STAT_OK;
          state      <= S_OUT;
          case (func_q)
            FUNC_FORMAT: begin
              free_head      <= '0;
              free_total     <= block_count;
              provided_total <= block_count;
            end
            FUNC_ACQUIRE: begin
              if (free_total == '0 || free_head >= provided_total) begin
                res_status <= STAT_EMPTY;
              end else begin
                res_addr  <= sum[AddrW-1:0];
                res_index <= free_head;
                state     <= S_LINK;
              end
            end
            FUNC_RELEASE: begin
              res_own <= own;
              if (own != OWN_INSIDE) begin
                res_status <= STAT_NOT_OWNED;
              end else begin
                state <= S_DIV;
              end
            end
            default: begin
              res_own <= own;
            end
          endcase
        end
        S_LINK: begin
          free_head  <= link_data;
          free_total <= free_total - 1'b1;
          state      <= S_OUT;
        end
        S_DIV: begin
          if (div_res.done) begin
            state <= S_OUT;
            if (div_res.remainder != '0) begin
              res_status <= STAT_MISALIGN;
            end else if (!rel_ok) begin
              res_status <= STAT_NOT_OWNED;
            end else begin
              free_head <= div_res.quotient[IdxW-1:0];
              res_index <= div_res.quotient[IdxW-1:0];
              if (free_total != '1) begin
                free_total <= free_total + 1'b1;
              end
            end
          end
        end
        S_OUT: begin
          if (out_load) begin
            block_address <= res_addr;
            block_index   <= res_index;
            ownership     <= res_own;
            free_count    <= free_total;
            status        <= res_status;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/efla_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// efla_checker
// Port-level checks for the allocator core, bound to the top level.
// ----------------------------------------------------------------------------
module efla_checker
  import efla_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [AddrW-1:0] block_address,
  input logic [IdxW-1:0]  block_index,
  input logic [1:0]       ownership,
  input logic [1:0]       status
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(block_address) &&
      $stable(block_index) && $stable(status))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a transaction while one is in flight");

  a_err_no_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_OK |-> block_index == '0)
    else $error("failed operation reports a block index");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_EMPTY |-> block_address == '0 && ownership == OWN_BELOW)
    else $error("empty-chunk result carries data");

endmodule

bind embedded_free_list_block_allocator_core efla_checker u_efla_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .block_address (block_address),
  .block_index   (block_index),
  .ownership     (ownership),
  .status        (status)
);

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the free-list block allocator core. A driver and a
// monitor, both clocked processes, move transactions over the valid/ready
// channels with random gaps on both sides. Every accepted operation runs
// through a local model of the chunk (link table, head, free and provided
// counts), and each returned transaction is checked field by field against
// the oldest prediction. Register settings change between phases, only while
// the core is idle, and cover the extremes of size, count and base address.
// ----------------------------------------------------------------------------
module testbench;
  import efla_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    func_t       op;
    logic [31:0] addr;
  } alloc_op_t;

  typedef struct {
    logic [31:0] blk_addr;
    logic [7:0]  blk_idx;
    logic [1:0]  own;
    logic [7:0]  free;
    logic [1:0]  stat;
  } alloc_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = REG_BLOCK_SIZE;
  logic [AddrW-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       func = FUNC_FORMAT;
  logic [AddrW-1:0] address = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [AddrW-1:0] block_address;
  logic [IdxW-1:0]  block_index;
  logic [1:0]       ownership;
  logic [IdxW-1:0]  free_count;
  logic [1:0]       status;

  embedded_free_list_block_allocator_core uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .func          (func),
    .address       (address),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .block_address (block_address),
    .block_index   (block_index),
    .ownership     (ownership),
    .free_count    (free_count),
    .status        (status)
  );

  always #5 clk = ~clk;

  // chunk model
  logic [7:0]  link_next [0:MaxBlocks-1];
  logic [7:0]  head_idx;
  logic [7:0]  free_left;
  logic [7:0]  chunk_blocks;
  logic [12:0] cfg_size;
  logic [7:0]  cfg_count;
  logic [31:0] cfg_base;

  alloc_op_t    op_backlog [$];
  alloc_reply_t chunk_replies [$];

  int  op_total = 0;
  int  results_seen = 0;
  int  error_count = 0;
  int  tx_gap_max = 3;
  int  rx_gap_max = 3;
  int  tx_wait = 0;
  int  rx_wait = 0;
  logic in_taken = 1'b0;
  logic out_taken = 1'b0;

  function automatic logic [63:0] unit_bytes();
    return (cfg_size == 13'd0) ? 64'd1 : 64'(cfg_size);
  endfunction

  task automatic chunk_reset();
    int i;
    for (i = 0; i < MaxBlocks; i++) link_next[i] = 8'(i + 1);
    head_idx     = 8'd0;
    free_left    = 8'(MaxBlocks);
    chunk_blocks = 8'(MaxBlocks);
    cfg_size     = 13'd16;
    cfg_count    = 8'd255;
    cfg_base     = 32'd0;
  endtask

  task automatic chunk_step(input func_t op, input logic [31:0] addr,
                            output alloc_reply_t r);
    logic [63:0] step, top, off, slot;
    int i;
    r = '{32'd0, 8'd0, OWN_BELOW, 8'd0, STAT_OK};
    step = unit_bytes();
    top  = 64'(cfg_base) + step * 64'(chunk_blocks);
    if (op == FUNC_RELEASE || op == FUNC_QUERY) begin
      if (64'(addr) < 64'(cfg_base)) r.own = OWN_BELOW;
      else if (64'(addr) >= top) r.own = OWN_ABOVE;
      else r.own = OWN_INSIDE;
    end
    case (op)
      FUNC_FORMAT: begin
        for (i = 0; i < MaxBlocks; i++) link_next[i] = 8'(i + 1);
        head_idx     = 8'd0;
        free_left    = cfg_count;
        chunk_blocks = cfg_count;
      end
      FUNC_ACQUIRE: begin
        if (free_left == 8'd0 || head_idx >= chunk_blocks || head_idx >= MaxBlocks) begin
          r.stat = STAT_EMPTY;
        end else begin
          r.blk_addr = 32'(64'(cfg_base) + step * 64'(head_idx));
          r.blk_idx  = head_idx;
          head_idx   = link_next[head_idx];
          free_left  = free_left - 8'd1;
        end
      end
      FUNC_RELEASE: begin
        off  = 64'(addr) - 64'(cfg_base);
        slot = off / step;
        if (r.own != OWN_INSIDE) r.stat = STAT_NOT_OWNED;
        else if (off % step != 64'd0) r.stat = STAT_MISALIGN;
        else if (slot >= MaxBlocks) r.stat = STAT_NOT_OWNED;
        else begin
          // double release is not caught; count saturates
          link_next[slot] = head_idx;
          head_idx = 8'(slot);
          if (free_left != 8'hFF) free_left = free_left + 8'd1;
          r.blk_idx = 8'(slot);
        end
      end
      default: ;
    endcase
    r.free = free_left;
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    error_count++;
    $display("%0t ns: %s expected %0h, got %0h", $time, what, want, got);
  endtask

  task automatic queue_op(input func_t op, input logic [31:0] a);
    alloc_op_t item;
    item.op   = op;
    item.addr = a;
    op_backlog.push_back(item);
    op_total++;
  endtask

  function automatic logic [31:0] pick_address(input int kind, input int span);
    logic [63:0] step, top;
    step = unit_bytes();
    top  = 64'(cfg_base) + step * 64'(span);
    case (kind)
      0: return $urandom;
      1: return 32'(64'(cfg_base) + step * $urandom_range(0, span + 1));
      2: return 32'(64'(cfg_base) + step * $urandom_range(0, span) +
                    $urandom_range(1, (step > 1) ? 32'(step - 1) : 1));
      3: return (cfg_base == 32'd0) ? 32'd0 : $urandom_range(0, cfg_base - 1);
      default: begin
        case ($urandom_range(0, 5))
          0: return cfg_base;
          1: return cfg_base - 32'd1;
          2: return 32'(top - 64'd1);
          3: return 32'(top);
          4: return 32'd0;
          default: return 32'hFFFF_FFFF;
        endcase
      end
    endcase
  endfunction

  // Queue a mix that is mostly well-formed: acquires, releases of blocks that
  // are off the free list right now, and rare formats, with noise mixed in.
  task automatic queue_batch(input int n, input bit lead_format);
    logic [7:0] in_use [$];
    bit         on_list [0:MaxBlocks-1];
    logic [7:0] p;
    int         i, r, pick, span;
    span = chunk_blocks;
    for (i = 0; i < MaxBlocks; i++) on_list[i] = 1'b0;
    p = head_idx;
    for (i = 0; i < free_left && p < MaxBlocks && !on_list[p]; i++) begin
      on_list[p] = 1'b1;
      p = link_next[p];
    end
    for (i = 0; i < span; i++)
      if (!on_list[i]) in_use.push_back(8'(i));
    if (lead_format) begin
      queue_op(FUNC_FORMAT, $urandom);
      in_use.delete();
      span = cfg_count;
    end
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        queue_op(FUNC_ACQUIRE, $urandom);
      end else if (r < 75 && in_use.size() > 0) begin
        pick = $urandom_range(0, in_use.size() - 1);
        queue_op(FUNC_RELEASE, 32'(64'(cfg_base) + unit_bytes() * 64'(in_use[pick])));
        in_use.delete(pick);
      end else if (r < 78) begin
        queue_op(FUNC_FORMAT, $urandom);
        in_use.delete();
        span = cfg_count;
      end else if (r < 88) begin
        queue_op(FUNC_QUERY, pick_address($urandom_range(0, 4), span));
      end else begin
        queue_op(FUNC_RELEASE, pick_address($urandom_range(0, 4), span));
      end
    end
  endtask

  task automatic wait_idle();
    while (op_backlog.size() != 0 || in_valid || chunk_replies.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BLOCK_SIZE:   cfg_size  = val[12:0];
      REG_BLOCK_COUNT:  cfg_count = val[7:0];
      REG_BASE_ADDRESS: cfg_base  = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // request driver
  always @(negedge clk) begin
    alloc_op_t item;
    if (rst) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else if (!in_valid || in_taken) begin
      if (in_taken) tx_wait = $urandom_range(0, tx_gap_max);
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (op_backlog.size() > 0) begin
        item = op_backlog.pop_front();
        func     <= item.op;
        address  <= item.addr;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // response side ready, with an occasional long hold-off to back up the core
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_taken) begin
        rx_wait = $urandom_range(0, rx_gap_max);
        if (results_seen % 397 == 150) rx_wait = 300;
      end
      if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // monitor: check returned transactions, predict accepted ones
  always @(posedge clk) begin
    alloc_reply_t want, got;
    if (rst) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_valid && in_ready;
      out_taken <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        got = '{block_address, block_index, ownership, free_count, status};
        results_seen++;
        if (chunk_replies.size() == 0) begin
          report_mismatch("transaction with no prediction, block_address", 32'd0,
                          got.blk_addr);
        end else begin
          want = chunk_replies.pop_front();
          if (got.blk_addr !== want.blk_addr)
            report_mismatch("block_address", want.blk_addr, got.blk_addr);
          if (got.blk_idx !== want.blk_idx)
            report_mismatch("block_index", 32'(want.blk_idx), 32'(got.blk_idx));
          if (got.own !== want.own)
            report_mismatch("ownership", 32'(want.own), 32'(got.own));
          if (got.free !== want.free)
            report_mismatch("free_count", 32'(want.free), 32'(got.free));
          if (got.stat !== want.stat)
            report_mismatch("status", 32'(want.stat), 32'(got.stat));
        end
      end
      if (in_valid && in_ready) begin
        chunk_step(func_t'(func), address, want);
        chunk_replies.push_back(want);
      end
    end
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int          phase, batch;
    logic [12:0] new_size;
    logic [7:0]  new_count;
    logic [31:0] new_base;
    chunk_reset();
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: 16-byte blocks, 255 blocks at address 0
    queue_op(FUNC_QUERY, 32'd0);
    queue_op(FUNC_QUERY, 32'hFFFF_FFFF);
    queue_op(FUNC_QUERY, 32'd4080);
    queue_op(FUNC_QUERY, 32'd4079);
    queue_op(FUNC_ACQUIRE, 32'd0);
    queue_op(FUNC_ACQUIRE, 32'hFFFF_FFFF);
    queue_op(FUNC_ACQUIRE, 32'd0);
    queue_op(FUNC_RELEASE, 32'd16);
    queue_op(FUNC_RELEASE, 32'd17);
    queue_op(FUNC_RELEASE, 32'd4080);
    queue_op(FUNC_RELEASE, 32'hFFFF_FFFF);
    queue_op(FUNC_ACQUIRE, 32'd0);
    queue_op(FUNC_RELEASE, 32'd0);
    queue_op(FUNC_RELEASE, 32'd0);
    queue_op(FUNC_FORMAT, 32'hFFFF_FFFF);
    queue_op(FUNC_RELEASE, 32'd32);
    queue_op(FUNC_ACQUIRE, 32'd0);
    wait_idle();

    // zero block size acts as one byte; two-block chunk at 0x1000
    write_reg(REG_BASE_ADDRESS, 32'h0000_1000);
    write_reg(REG_BLOCK_SIZE, 32'd0);
    write_reg(REG_BLOCK_COUNT, 32'd2);
    queue_op(FUNC_QUERY, 32'h0000_0FFF);
    queue_op(FUNC_RELEASE, 32'd0);
    queue_op(FUNC_FORMAT, 32'd0);
    queue_op(FUNC_ACQUIRE, 32'd0);
    queue_op(FUNC_ACQUIRE, 32'd0);
    queue_op(FUNC_ACQUIRE, 32'd0);
    queue_op(FUNC_RELEASE, 32'h0000_1000);
    queue_op(FUNC_QUERY, 32'h0000_1002);
    wait_idle();

    for (phase = 0; op_total < 1225; phase++) begin
      case (phase)
        0: begin new_size = 13'd0;    new_count = 8'd1;   new_base = 32'hFFFF_FFFF; end
        1: begin new_size = 13'd4096; new_count = 8'd255; new_base = 32'hFFFF_0000; end
        2: begin new_size = 13'd8191; new_count = 8'd17;  new_base = $urandom;      end
        3: begin new_size = 13'd1;    new_count = 8'd0;   new_base = 32'd0;         end
        4: begin new_size = 13'd3;    new_count = 8'd5;   new_base = 32'd100;       end
        5: begin new_size = 13'd16;   new_count = 8'd255; new_base = 32'd0;         end
        default: begin
          new_size  = ($urandom_range(0, 3) == 0) ? 13'($urandom) :
                      13'($urandom_range(1, 64));
          new_count = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) :
                      8'($urandom_range(1, 20));
          new_base  = $urandom;
        end
      endcase
      write_reg(REG_BLOCK_SIZE,
                (phase % 2 == 1) ? (($urandom & 32'hFFFF_E000) | 32'(new_size)) :
                32'(new_size));
      write_reg(REG_BLOCK_COUNT,
                (phase % 2 == 1) ? (($urandom & 32'hFFFF_FF00) | 32'(new_count)) :
                32'(new_count));
      write_reg(REG_BASE_ADDRESS, new_base);
      if (phase == 2) write_reg(REG_UNUSED, $urandom);
      for (batch = 0; batch < 3; batch++) begin
        case ($urandom_range(0, 2))
          0: tx_gap_max = 0;
          1: tx_gap_max = 4;
          default: tx_gap_max = 12;
        endcase
        case ($urandom_range(0, 2))
          0: rx_gap_max = 0;
          1: rx_gap_max = 4;
          default: rx_gap_max = 12;
        endcase
        queue_batch(40, batch == 0 && phase % 4 != 3);
        wait_idle();
      end
    end

    repeat (60) @(posedge clk);
    if (chunk_replies.size() != 0)
      report_mismatch("predictions left undelivered", 32'd0, 32'(chunk_replies.size()));
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
